// File: rtl/dbscan_pkg.sv
// ----------------------------------------------------------------------------
// dbscan_pkg
// Shared types, constants and command/status structs for the DBSCAN block.
// ----------------------------------------------------------------------------
`default_nettype none

package dbscan_pkg;

    localparam int POINTS     = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CNT_BITS   = $clog2(POINTS + 1);
    localparam int EPS_BITS   = 33;
    localparam int MINN_BITS  = 7;
    localparam int LABEL_BITS = 7;
    localparam int CFG_BITS   = 33;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;

    localparam logic [0:0] REG_EPS_SQUARED    = 1'd0;
    localparam logic [0:0] REG_MIN_NEIGHBOURS = 1'd1;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic               last_point;
    } in_item_t;

    typedef struct packed {
        logic [5:0] point_index;
        logic [6:0] cluster_label;
        logic       last_label;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic                store_point;
        logic                load_centre;  // latch centre coords from centre_idx
        logic [IDX_BITS-1:0] centre_idx;
        logic                compare;      // k_idx valid this cycle
        logic [IDX_BITS-1:0] k_idx;
    } dp_cmd_t;

    // Datapath to controller (registered pipeline result).
    typedef struct packed {
        logic                nb_valid;
        logic                nb_hit;
        logic [IDX_BITS-1:0] nb_idx;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/dbscan_datapath.sv
// ----------------------------------------------------------------------------
// dbscan_datapath
// Coordinate stores and a three-stage squared-distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module dbscan_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dbscan_pkg::dp_cmd_t               cmd,
    input  wire dbscan_pkg::in_item_t              item,
    input  wire logic [dbscan_pkg::IDX_BITS-1:0]   wr_idx,
    input  wire logic [dbscan_pkg::EPS_BITS-1:0]   eps_squared,
    output dbscan_pkg::dp_status_t                 status
);

    localparam int CB = dbscan_pkg::COORD_BITS;
    localparam int DB = dbscan_pkg::DIFF_BITS;
    localparam int SB = dbscan_pkg::SQ_BITS;
    localparam int TB = dbscan_pkg::DIST_BITS;
    localparam int IB = dbscan_pkg::IDX_BITS;

    logic signed [CB-1:0] x_mem [dbscan_pkg::POINTS];
    logic signed [CB-1:0] y_mem [dbscan_pkg::POINTS];

    logic signed [CB-1:0] cx_reg, cy_reg;
    logic signed [CB-1:0] kx_reg, ky_reg;
    logic                 s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [IB-1:0]        s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [SB-1:0]        sqx_reg, sqy_reg;
    logic                 hit_reg;
    logic signed [DB-1:0] dx, dy;
    logic [TB-1:0]        dist_sum;

    always_ff @(posedge clk)
    begin
        if (cmd.store_point)
        begin
            x_mem[wr_idx] <= item.x_coord[CB-1:0];
            y_mem[wr_idx] <= item.y_coord[CB-1:0];
        end
        if (cmd.load_centre)
        begin
            cx_reg <= x_mem[cmd.centre_idx];
            cy_reg <= y_mem[cmd.centre_idx];
        end
        kx_reg <= x_mem[cmd.k_idx];
        ky_reg <= y_mem[cmd.k_idx];
    end

    assign dx       = DB'(cx_reg) - DB'(kx_reg);
    assign dy       = DB'(cy_reg) - DB'(ky_reg);
    assign dist_sum = TB'(sqx_reg) + TB'(sqy_reg);

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= cmd.k_idx;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        sqx_reg    <= SB'(dx * dx);
        sqy_reg    <= SB'(dy * dy);
        hit_reg    <= (dist_sum != '0) && (dist_sum <= TB'(eps_squared));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.compare;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    assign status.nb_valid = s3_vld_reg;
    assign status.nb_hit   = hit_reg;
    assign status.nb_idx   = s3_idx_reg;

endmodule

`default_nettype wire

// File: rtl/dbscan_controller.sv
// ----------------------------------------------------------------------------
// dbscan_controller
// Load, region-query, queue expansion and label output sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module dbscan_controller (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               in_last,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output dbscan_pkg::out_item_t                   out_item,
    input  wire logic [dbscan_pkg::MINN_BITS-1:0]   min_neighbours,
    output dbscan_pkg::dp_cmd_t                     cmd,
    output logic [dbscan_pkg::IDX_BITS-1:0]         wr_idx,
    input  wire dbscan_pkg::dp_status_t             status
);

    localparam int IB = dbscan_pkg::IDX_BITS;
    localparam int CB = dbscan_pkg::CNT_BITS;
    localparam int LB = dbscan_pkg::LABEL_BITS;
    localparam int NP = dbscan_pkg::POINTS;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_OUTER  = 4'd2;
    localparam logic [3:0] S_CENTRE = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_DRAIN  = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_POP    = 4'd7;
    localparam logic [3:0] S_LBLRD  = 4'd8;
    localparam logic [3:0] S_LBLWR  = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_EMITRD = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CB-1:0] count_reg;
    logic [CB-1:0] i_reg;        // outer point / sweep index
    logic [CB-1:0] k_reg;        // scan index
    logic [CB-1:0] head_reg, tail_reg;
    logic [CB-1:0] nb_cnt_reg;
    logic [IB-1:0] p_reg;
    logic          expanding_reg;
    logic [LB-1:0] cluster_reg;
    logic [NP-1:0] visited_reg;
    logic [NP-1:0] queued_reg;
    logic [NP-1:0] nb_reg;       // neighbour set of the current centre
    logic          out_vld_reg;
    dbscan_pkg::out_item_t out_reg;

    logic [LB-1:0] label_mem [NP];
    logic [IB-1:0] queue_mem [NP];
    logic [LB-1:0] lbl_rd_reg;
    logic [IB-1:0] q_rd_reg;
    logic          lbl_we;
    logic [IB-1:0] lbl_wa, lbl_ra;
    logic [LB-1:0] lbl_wd;
    logic          is_core;
    logic [NP-1:0] new_q;
    logic [IB-1:0] new_idx;
    logic          new_any;
    logic [CB-1:0] last_idx;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;
    assign wr_idx    = count_reg[IB-1:0];
    assign last_idx  = count_reg - CB'(1);
    assign is_core   = (nb_cnt_reg >= CB'(min_neighbours));

    // Neighbours not yet queued, pushed one per cycle in ascending order.
    assign new_q = nb_reg & ~queued_reg;
    always_comb
    begin
        new_idx = '0;
        new_any = 1'b0;
        for (int j = NP - 1; j >= 0; j--)
        begin
            if (new_q[j])
            begin
                new_idx = IB'(j);
                new_any = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lbl_we)
            label_mem[lbl_wa] <= lbl_wd;
        lbl_rd_reg <= label_mem[lbl_ra];
        if (state_reg == S_DECIDE && expanding_reg && is_core && new_any)
            queue_mem[tail_reg[IB-1:0]] <= new_idx;
        q_rd_reg <= queue_mem[head_reg[IB-1:0]];
    end

    always_comb
    begin
        lbl_we = 1'b0;
        lbl_wa = i_reg[IB-1:0];
        lbl_wd = '0;
        lbl_ra = p_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                lbl_we = 1'b1;
            end
            S_LBLWR:
            begin
                lbl_we = (lbl_rd_reg == '0);
                lbl_wa = p_reg;
                lbl_wd = cluster_reg;
            end
            S_EMIT, S_EMITRD:
            begin
                lbl_ra = i_reg[IB-1:0];
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_DECIDE && !expanding_reg && is_core)
        begin
            lbl_we = 1'b1;
            lbl_wa = i_reg[IB-1:0];
            lbl_wd = cluster_reg + LB'(1);
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.store_point = in_valid && in_ready && (count_reg < CB'(NP));
        cmd.centre_idx  = expanding_reg ? p_reg : i_reg[IB-1:0];
        cmd.load_centre = (state_reg == S_CENTRE);
        cmd.k_idx       = k_reg[IB-1:0];
        cmd.compare     = (state_reg == S_SCAN);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
                if (in_valid && in_last)
                    state_next = S_CLEAR;
            S_CLEAR:
                if (i_reg == count_reg - CB'(1))
                    state_next = S_OUTER;
            S_OUTER:
                if (i_reg == count_reg)
                    state_next = S_EMITRD;
                else if (!visited_reg[i_reg[IB-1:0]])
                    state_next = S_CENTRE;
            S_CENTRE:
                state_next = S_SCAN;
            S_SCAN:
                if (k_reg == count_reg - CB'(1))
                    state_next = S_DRAIN;
            S_DRAIN:
                if (status.nb_valid && status.nb_idx == last_idx[IB-1:0])
                    state_next = S_DECIDE;
            S_DECIDE:
                if (!expanding_reg)
                begin
                    if (!is_core)
                        state_next = S_OUTER;
                end
                else if (!is_core || !new_any)
                    state_next = S_POP;
            S_POP:
                if (head_reg == tail_reg)
                    state_next = S_OUTER;
                else
                    state_next = S_LBLRD;
            S_LBLRD:
                state_next = S_LBLWR;
            S_LBLWR:
                state_next = visited_reg[p_reg] ? S_POP : S_CENTRE;
            S_EMITRD:
                state_next = S_EMIT;
            S_EMIT:
                if (!out_vld_reg || out_ready)
                    state_next = (i_reg == count_reg - CB'(1)) ? S_LOAD : S_EMITRD;
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            nb_cnt_reg    <= '0;
            p_reg         <= '0;
            expanding_reg <= 1'b0;
            cluster_reg   <= '0;
            visited_reg   <= '0;
            queued_reg    <= '0;
            nb_reg        <= '0;
            out_vld_reg   <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && (!out_vld_reg || out_ready))
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    i_reg <= '0;
                    if (cmd.store_point)
                        count_reg <= count_reg + CB'(1);
                    if (in_valid && in_last)
                    begin
                        visited_reg <= '0;
                        cluster_reg <= '0;
                        expanding_reg <= 1'b0;
                    end
                end
                S_CLEAR:
                    i_reg <= (i_reg == count_reg - CB'(1)) ? '0 : i_reg + CB'(1);
                S_OUTER:
                begin
                    expanding_reg <= 1'b0;
                    if (i_reg == count_reg)
                        i_reg <= '0;
                    else if (visited_reg[i_reg[IB-1:0]])
                        i_reg <= i_reg + CB'(1);
                    else
                        visited_reg[i_reg[IB-1:0]] <= 1'b1;
                end
                S_CENTRE:
                begin
                    k_reg      <= '0;
                    nb_cnt_reg <= '0;
                    nb_reg     <= '0;
                end
                S_SCAN:
                begin
                    if (k_reg != count_reg - CB'(1))
                        k_reg <= k_reg + CB'(1);
                    if (status.nb_valid && status.nb_hit)
                    begin
                        nb_reg[status.nb_idx] <= 1'b1;
                        nb_cnt_reg <= nb_cnt_reg + CB'(1);
                    end
                end
                S_DRAIN:
                    if (status.nb_valid && status.nb_hit)
                    begin
                        nb_reg[status.nb_idx] <= 1'b1;
                        nb_cnt_reg <= nb_cnt_reg + CB'(1);
                    end
                S_DECIDE:
                begin
                    if (!expanding_reg)
                    begin
                        if (is_core)
                        begin
                            cluster_reg   <= cluster_reg + LB'(1);
                            expanding_reg <= 1'b1;
                            queued_reg    <= NP'(1) << i_reg[IB-1:0];
                            head_reg      <= '0;
                            tail_reg      <= '0;
                        end
                        else
                            i_reg <= i_reg + CB'(1);
                    end
                    else if (is_core && new_any)
                    begin
                        queued_reg[new_idx] <= 1'b1;
                        tail_reg <= tail_reg + CB'(1);
                    end
                end
                S_POP:
                    if (head_reg == tail_reg)
                        i_reg <= i_reg + CB'(1);
                    else
                    begin
                        p_reg    <= q_rd_reg;
                        head_reg <= head_reg + CB'(1);
                    end
                S_LBLRD:
                begin
                end
                S_LBLWR:
                    if (!visited_reg[p_reg])
                        visited_reg[p_reg] <= 1'b1;
                S_EMITRD:
                begin
                end
                S_EMIT:
                    if (!out_vld_reg || out_ready)
                    begin
                        out_reg.point_index   <= 6'(i_reg[IB-1:0]);
                        out_reg.cluster_label <= lbl_rd_reg;
                        out_reg.last_label    <= (i_reg == count_reg - CB'(1));
                        if (i_reg == count_reg - CB'(1))
                            count_reg <= '0;
                        else
                            i_reg <= i_reg + CB'(1);
                    end
                default:
                begin
                end
            endcase
        end
    end

    property p_tail_bound;
        @(posedge clk) disable iff (!rst_n) tail_reg <= CB'(NP);
    endproperty
    a_tail_bound: assert property (p_tail_bound) else $error("queue overrun");

    property p_head_tail;
        @(posedge clk) disable iff (!rst_n) head_reg <= tail_reg || state_reg == S_DECIDE;
    endproperty
    a_head_tail: assert property (p_head_tail) else $error("queue underrun");

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= CB'(NP);
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("point count overflow");

    property p_no_in_while_busy;
        @(posedge clk) disable iff (!rst_n) out_vld_reg |-> !in_ready || state_reg == S_LOAD;
    endproperty
    a_no_in_while_busy: assert property (p_no_in_while_busy)
        else $error("input taken while busy");

endmodule

`default_nettype wire

// File: rtl/dbscan_point_clustering.sv
// ----------------------------------------------------------------------------
// dbscan_point_clustering
// DBSCAN clustering of up to 64 two-dimensional points.
// ----------------------------------------------------------------------------
// Points load one per request. The request marked last starts clustering:
// each region query streams every stored point through a three-stage
// squared-distance pipeline, and each point is queried once. Labels then
// leave in load order, each read in S_EMITRD and sent from S_EMIT, which
// waits while the output is stalled; no input request is taken until the
// last label has been registered for output. Configuration must be written
// only while idle; the block does not enforce this.
`default_nettype none

module dbscan_point_clustering (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire dbscan_pkg::in_item_t                in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output dbscan_pkg::out_item_t                    out_data,
    input  wire logic                                cfg_we,
    input  wire logic [0:0]                          cfg_index,
    input  wire logic [dbscan_pkg::CFG_BITS-1:0]     cfg_data
);

    logic [dbscan_pkg::EPS_BITS-1:0]  eps_reg;
    logic [dbscan_pkg::MINN_BITS-1:0] minn_reg;
    dbscan_pkg::dp_cmd_t              cmd;
    dbscan_pkg::dp_status_t           status;
    logic [dbscan_pkg::IDX_BITS-1:0]  wr_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= '0;
            minn_reg <= dbscan_pkg::MINN_BITS'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dbscan_pkg::REG_EPS_SQUARED:
                    eps_reg <= cfg_data[dbscan_pkg::EPS_BITS-1:0];
                dbscan_pkg::REG_MIN_NEIGHBOURS:
                    minn_reg <= cfg_data[dbscan_pkg::MINN_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    dbscan_controller u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_last        (in_data.last_point),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_data),
        .min_neighbours (minn_reg),
        .cmd            (cmd),
        .wr_idx         (wr_idx),
        .status         (status)
    );

    dbscan_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item        (in_data),
        .wr_idx      (wr_idx),
        .eps_squared (eps_reg),
        .status      (status)
    );

endmodule

`default_nettype wire
